[rtl/bal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list package
// Sizes, codes and word types that the bounded array list modules share.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 9;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_POP,
		S_SHIFT,
		S_PUT
	} state_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item_out;
		logic [COUNT_W-1:0]       count;
	} rsp_t;

endpackage

[rtl/bal_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/bal_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list sequencer
// Clears the store after reset, decodes each request and steps the shared
// index counter through the store to move entries up on an insert.
// ----------------------------------------------------------------------------
module bal_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bal_pkg::req_t                 req,
	input  logic                          rsp_busy,
	output logic                          res_valid,
	output bal_pkg::rsp_t                 res,
	output logic                          ram_we,
	output logic [bal_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [bal_pkg::DATA_W-1:0]    ram_wdata,
	output logic [bal_pkg::ADDR_W-1:0]    ram_raddr,
	input  logic [bal_pkg::DATA_W-1:0]    ram_rdata
);

	bal_pkg::state_t state_q, state_d;
	logic [bal_pkg::CNT_W-1:0]  count_q, count_d;
	logic [bal_pkg::ADDR_W-1:0] k_q, k_d;
	logic [bal_pkg::ADDR_W-1:0] pos_q, pos_d;
	logic [bal_pkg::DATA_W-1:0] item_q, item_d;
	logic [bal_pkg::ADDR_W-1:0] k_dec;
	logic [bal_pkg::CMP_W-1:0]  pos_w;
	logic [bal_pkg::CMP_W-1:0]  cnt_w;
	logic [bal_pkg::CMP_W-1:0]  cap_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bal_pkg::S_CLEAR;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		item_q <= item_d;
	end

	assign k_dec = k_q - bal_pkg::ADDR_W'(1);
	assign pos_w = bal_pkg::CMP_W'(req.position);
	assign cnt_w = bal_pkg::CMP_W'(count_q);
	assign cap_w = bal_pkg::CMP_W'(bal_pkg::CAPACITY);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		k_d       = k_q;
		pos_d     = pos_q;
		item_d    = item_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		res_valid = 1'b0;
		res       = '0;
		req_stall = 1'b1;

		unique case (state_q)
			bal_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				k_d       = k_q + bal_pkg::ADDR_W'(1);
				if (k_q == bal_pkg::ADDR_W'(bal_pkg::CAPACITY - 1)) begin
					k_d     = '0;
					state_d = bal_pkg::S_IDLE;
				end
			end
			bal_pkg::S_IDLE: begin
				req_stall = rsp_busy;
				if (req_valid && !rsp_busy) begin
					res_valid = 1'b1;
					res.status = bal_pkg::ST_OK;
					unique case (req.opcode)
						bal_pkg::OP_APPEND: begin
							if (cnt_w >= cap_w) begin
								res.status = bal_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[bal_pkg::ADDR_W-1:0];
								ram_wdata = req.item_in;
								count_d   = count_q + bal_pkg::CNT_W'(1);
							end
						end
						bal_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								res.status = bal_pkg::ST_EMPTY;
							end else begin
								res_valid = 1'b0;
								count_d   = count_q - bal_pkg::CNT_W'(1);
								ram_raddr = count_d[bal_pkg::ADDR_W-1:0];
								state_d   = bal_pkg::S_POP;
							end
						end
						bal_pkg::OP_INSERT: begin
							if (pos_w >= cap_w) begin
								res.status = bal_pkg::ST_FULL;
							end else if (pos_w >= cnt_w) begin
								ram_we    = 1'b1;
								ram_waddr = pos_w[bal_pkg::ADDR_W-1:0];
								ram_wdata = req.item_in;
								count_d   = bal_pkg::CNT_W'(pos_w + bal_pkg::CMP_W'(1));
							end else if (cnt_w >= cap_w) begin
								res.status = bal_pkg::ST_FULL;
							end else begin
								res_valid = 1'b0;
								pos_d     = pos_w[bal_pkg::ADDR_W-1:0];
								item_d    = req.item_in;
								k_d       = count_q[bal_pkg::ADDR_W-1:0];
								ram_raddr = count_q[bal_pkg::ADDR_W-1:0]
									- bal_pkg::ADDR_W'(1);
								state_d   = bal_pkg::S_SHIFT;
							end
						end
						default: begin
							res.status = bal_pkg::ST_OK;
						end
					endcase
					res.count = bal_pkg::COUNT_W'(count_d);
				end
			end
			bal_pkg::S_POP: begin
				res_valid     = 1'b1;
				res.status    = bal_pkg::ST_OK;
				res.item_out  = ram_rdata;
				res.count     = bal_pkg::COUNT_W'(count_q);
				state_d       = bal_pkg::S_IDLE;
			end
			bal_pkg::S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = ram_rdata;
				k_d       = k_dec;
				ram_raddr = k_dec - bal_pkg::ADDR_W'(1);
				if (k_dec == pos_q) begin
					state_d = bal_pkg::S_PUT;
				end
			end
			bal_pkg::S_PUT: begin
				ram_we     = 1'b1;
				ram_waddr  = pos_q;
				ram_wdata  = item_q;
				count_d    = count_q + bal_pkg::CNT_W'(1);
				res_valid  = 1'b1;
				res.status = bal_pkg::ST_OK;
				res.count  = bal_pkg::COUNT_W'(count_d);
				state_d    = bal_pkg::S_IDLE;
			end
			default: begin
				state_d = bal_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[rtl/bounded_array_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list
// A fixed-capacity list of signed 32-bit words held in one RAM, with a count
// of used entries, served by append, remove-last and insert-at-index requests.
//
// Requests arrive on req/req_valid/req_stall and each gives exactly one word
// on rsp/rsp_valid/rsp_stall carrying status, popped word and new count.
// A word is taken at a clock edge where valid is high and stall is low.
// Append, an insert at or past the end, and any request that fails give their
// response word in the cycle after acceptance. Remove passes through the S_POP
// state, since the popped entry comes from the RAM's registered read port.
// An insert inside the list moves entries up one per cycle through the single
// RAM write port in S_SHIFT, then writes the new word at its position in S_PUT.
// One request is in the block at a time; req_stall stays high until its
// response has been registered and that response has left the output stage.
// After reset the store is swept to zero, one entry a cycle, across all 256
// entries, with req_stall held high. A stalled response simply holds in the
// output register, and no further request is taken until it is delivered.
// ----------------------------------------------------------------------------
module bounded_array_list (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bal_pkg::rsp_t rsp
);

	logic                       res_valid;
	bal_pkg::rsp_t              res;
	logic                       rsp_valid_q;
	bal_pkg::rsp_t              rsp_q;
	logic                       ram_we;
	logic [bal_pkg::ADDR_W-1:0] ram_waddr;
	logic [bal_pkg::DATA_W-1:0] ram_wdata;
	logic [bal_pkg::ADDR_W-1:0] ram_raddr;
	logic [bal_pkg::DATA_W-1:0] ram_rdata;

	bal_ram #(
		.WIDTH(bal_pkg::DATA_W),
		.DEPTH(bal_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_busy  (rsp_valid_q),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
